FILE: src/bezier_throttle_curve_mapper_unit_macros.svh
// ----------------------------------------------------------------------------
// Bezier throttle curve mapper: assertion macros
// Shorthand for the concurrent checks of the mapper top level.
// ----------------------------------------------------------------------------
`ifndef BEZIER_THROTTLE_CURVE_MAPPER_UNIT_MACROS_SVH
`define BEZIER_THROTTLE_CURVE_MAPPER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BTCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define BTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/btcm_pkg.sv
// ----------------------------------------------------------------------------
// Bezier throttle curve mapper package
// Widths, register indexes, curve constants and the sequencer state type.
// ----------------------------------------------------------------------------
package btcm_pkg;

	// Converter sample width; the top eight bits form the curve index
	localparam int SAMPLE_BITS = 10;
	localparam int IDX_W       = 8;
	localparam int S_DATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int POWER_W    = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = CFG_IDX_W'(1);

	localparam logic [POWER_W-1:0] MIN_POWER_RST = 7'd1;
	localparam logic [POWER_W-1:0] MAX_POWER_RST = 7'd127;

	// Output byte
	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] RIGHT_OFFSET = 8'd127;

	// Datapath widths
	localparam int X_W    = 18;  // b^2 + 3a^2 and a^2 + 3b^2
	localparam int MD_W   = 25;  // cube multiplicand after seven shifts
	localparam int CUBE_W = 24;  // b^3 + 3a^2b and a^3 + 3ab^2, at most 255^3
	localparam int NUM_W  = 31;  // weighted numerator, below 128 * 255^3
	localparam int Q_W    = 7;   // command quotient, at most 127

	// Curve denominator 255^3 and the divisor aligned to the top quotient bit
	localparam logic [CUBE_W-1:0] CURVE_SPAN = 24'd16581375;
	localparam logic [NUM_W-1:0]  DIV_TOP    = NUM_W'(CURVE_SPAN) << (Q_W - 1);

	// Lane numbers
	localparam int LANE_L = 0;
	localparam int LANE_R = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_PREP,
		ST_CUBE,
		ST_MIX,
		ST_DIV,
		ST_CMP,
		ST_EMIT
	} state_t;

endpackage

FILE: src/bezier_throttle_curve_mapper_unit.sv
// ----------------------------------------------------------------------------
// Bezier throttle curve mapper
// Maps a left/right pair of throttle samples through a cubic Bezier curve and
// sends a command byte for each side whose command changed.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  left_sample, right_sample
// m_*       out        m_tvalid/m_tready  serial_byte, is_right, last
// cfg_*     in         cfg_valid/cfg_ready register index and data
//
// After accept a pair passes through squaring, setup, cubing, weighting, division and compare,
// set by the bit-serial shift-add multipliers and the restoring divider, then one send cycle
// per byte while the output is free. No new pair is taken before the last leaves the send state.
// Reset clears the remembered commands and loads the curve registers. A stalled
// output holds the send state and the input off; the last byte may wait meanwhile.
// ----------------------------------------------------------------------------
`include "bezier_throttle_curve_mapper_unit_macros.svh"

module bezier_throttle_curve_mapper_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [btcm_pkg::S_DATA_W-1:0]     s_tdata,    // left_sample, right_sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [btcm_pkg::BYTE_W-1:0]       m_tdata,    // serial_byte
	output logic [0:0]                        m_tuser,    // is_right
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [btcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [btcm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import btcm_pkg::*;

	state_t state_q, state_d;
	logic [2:0] cnt_q;

	logic [POWER_W-1:0] mn_q, mx_q;
	logic [POWER_W-1:0] mn_sh_q, mx_sh_q;
	logic [NUM_W-1:0]   dv_q;

	// Per-lane datapath registers
	logic [IDX_W-1:0]  idx_q  [2];
	logic [IDX_W-1:0]  mr0_q  [2];
	logic [IDX_W-1:0]  mr1_q  [2];
	logic [MD_W-1:0]   md0_q  [2];
	logic [MD_W-1:0]   md1_q  [2];
	logic [CUBE_W-1:0] acc0_q [2];
	logic [CUBE_W-1:0] acc1_q [2];
	logic [NUM_W-1:0]  wp_q   [2];
	logic [NUM_W-1:0]  wq_q   [2];
	logic [NUM_W-1:0]  num_q  [2];
	logic [Q_W-1:0]    quo_q  [2];

	logic [BYTE_W-1:0] last_cmd_q [2];
	logic [1:0]        pend_q, pend_d;

	logic              m_tvalid_q;
	logic [BYTE_W-1:0] m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;

	// Combinational lane results
	logic [CUBE_W-1:0] acc0_nx [2];
	logic [CUBE_W-1:0] acc1_nx [2];
	logic [X_W-1:0]    x_sum   [2];
	logic [X_W-1:0]    y_sum   [2];
	logic [NUM_W-1:0]  num_nx  [2];
	logic [NUM_W:0]    diff    [2];
	logic              ge      [2];
	logic [BYTE_W-1:0] cmd     [2];

	logic in_acc;
	logic out_free;
	logic load_l, load_r;

	// Lane arithmetic: shift-add steps, square combine, weighting, divide step
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			acc0_nx[k] = acc0_q[k] + (mr0_q[k][0] ? md0_q[k][CUBE_W-1:0] : '0);
			acc1_nx[k] = acc1_q[k] + (mr1_q[k][0] ? md1_q[k][CUBE_W-1:0] : '0);
			x_sum[k]   = X_W'(acc1_q[k][15:0]) + X_W'({acc0_q[k][15:0], 1'b0})
				+ X_W'(acc0_q[k][15:0]);
			y_sum[k]   = X_W'(acc0_q[k][15:0]) + X_W'({acc1_q[k][15:0], 1'b0})
				+ X_W'(acc1_q[k][15:0]);
			num_nx[k]  = num_q[k] + (mn_sh_q[0] ? wp_q[k] : '0)
				+ (mx_sh_q[0] ? wq_q[k] : '0);
			diff[k]    = {1'b0, num_q[k]} - {1'b0, dv_q};
			ge[k]      = !diff[k][NUM_W];
			cmd[k]     = BYTE_W'(quo_q[k]);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_SQR;
			ST_SQR:  if (cnt_q == 3'd7) state_d = ST_PREP;
			ST_PREP: state_d = ST_CUBE;
			ST_CUBE: if (cnt_q == 3'd7) state_d = ST_MIX;
			ST_MIX:  if (cnt_q == 3'(Q_W - 1)) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == 3'(Q_W - 1)) state_d = ST_CMP;
			ST_CMP:  state_d = ST_EMIT;
			ST_EMIT: if (pend_d == 2'b00) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshakes and byte selection
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		in_acc    = s_tvalid && s_tready;
		out_free  = !m_tvalid_q || m_tready;
		load_l    = (state_q == ST_EMIT) && out_free && pend_q[0];
		load_r    = (state_q == ST_EMIT) && out_free && !pend_q[0] && pend_q[1];
		pend_d    = pend_q & ~{load_r, load_l};
		if (state_q == ST_CMP) begin
			pend_d = {cmd[LANE_R] != last_cmd_q[LANE_R], cmd[LANE_L] != last_cmd_q[LANE_L]};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			mn_q          <= MIN_POWER_RST;
			mx_q          <= MAX_POWER_RST;
			last_cmd_q[0] <= '0;
			last_cmd_q[1] <= '0;
			pend_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 3'd0 : cnt_q + 3'd1;
			pend_q  <= pend_d;

			// Take register writes; other indexes are dropped
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MIN_POWER: mn_q <= cfg_data;
					REG_MAX_POWER: mx_q <= cfg_data;
					default: ;
				endcase
			end

			// Remember the new commands
			if (state_q == ST_CMP) begin
				last_cmd_q[LANE_L] <= cmd[LANE_L];
				last_cmd_q[LANE_R] <= cmd[LANE_R];
			end

			// Hold the output request until taken
			if (load_l || load_r) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath: shift registers and accumulators
	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			unique case (state_q) inside
				ST_IDLE: begin
					if (in_acc) begin
						idx_q[k]  <= s_tdata[k*SAMPLE_BITS + SAMPLE_BITS - 1 -: IDX_W];
						mr0_q[k]  <= s_tdata[k*SAMPLE_BITS + SAMPLE_BITS - 1 -: IDX_W];
						md0_q[k]  <= MD_W'(s_tdata[k*SAMPLE_BITS + SAMPLE_BITS - 1 -: IDX_W]);
						mr1_q[k]  <= ~s_tdata[k*SAMPLE_BITS + SAMPLE_BITS - 1 -: IDX_W];
						md1_q[k]  <= {{(MD_W - IDX_W){1'b0}},
							~s_tdata[k*SAMPLE_BITS + SAMPLE_BITS - 1 -: IDX_W]};
						acc0_q[k] <= '0;
						acc1_q[k] <= '0;
					end
				end
				ST_SQR, ST_CUBE: begin
					acc0_q[k] <= acc0_nx[k];
					acc1_q[k] <= acc1_nx[k];
					mr0_q[k]  <= mr0_q[k] >> 1;
					mr1_q[k]  <= mr1_q[k] >> 1;
					md0_q[k]  <= md0_q[k] << 1;
					md1_q[k]  <= md1_q[k] << 1;
					if (state_q == ST_CUBE && cnt_q == 3'd7) begin
						wp_q[k]  <= NUM_W'(acc0_nx[k]);
						wq_q[k]  <= NUM_W'(acc1_nx[k]);
						num_q[k] <= '0;
					end
				end
				ST_PREP: begin
					// b * (b^2 + 3a^2) and a * (a^2 + 3b^2)
					md0_q[k]  <= MD_W'(x_sum[k]);
					mr0_q[k]  <= ~idx_q[k];
					md1_q[k]  <= MD_W'(y_sum[k]);
					mr1_q[k]  <= idx_q[k];
					acc0_q[k] <= '0;
					acc1_q[k] <= '0;
				end
				ST_MIX: begin
					num_q[k] <= num_nx[k];
					wp_q[k]  <= wp_q[k] << 1;
					wq_q[k]  <= wq_q[k] << 1;
				end
				ST_DIV: begin
					if (ge[k]) num_q[k] <= diff[k][NUM_W-1:0];
					quo_q[k] <= {quo_q[k][Q_W-2:0], ge[k]};
				end
				default: ;
			endcase
		end

		// Shared weight and divisor shifters
		if (state_q == ST_CUBE && cnt_q == 3'd7) begin
			mn_sh_q <= mn_q;
			mx_sh_q <= mx_q;
		end else if (state_q == ST_MIX) begin
			mn_sh_q <= mn_sh_q >> 1;
			mx_sh_q <= mx_sh_q >> 1;
		end
		if (state_q == ST_MIX) begin
			dv_q <= DIV_TOP;
		end else if (state_q == ST_DIV) begin
			dv_q <= dv_q >> 1;
		end

		// Load the output register
		if (load_l) begin
			m_tdata_q <= cmd[LANE_L];
			m_tuser_q <= 1'b0;
			m_tlast_q <= !pend_q[1];
		end else if (load_r) begin
			m_tdata_q <= cmd[LANE_R] + RIGHT_OFFSET;
			m_tuser_q <= 1'b1;
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;
	assign m_tlast    = m_tlast_q;

	// Checks
	`BTCM_ASSERT_NOW(a_right_range, m_tvalid && m_tuser[0], m_tdata >= RIGHT_OFFSET, "right byte below offset")
	`BTCM_ASSERT_NOW(a_left_range, m_tvalid && !m_tuser[0], m_tdata <= RIGHT_OFFSET, "left byte above range")
	`BTCM_ASSERT_NOW(a_idle_no_pend, s_tready, pend_q == 2'b00, "input ready with bytes pending")
	`BTCM_ASSERT_NEXT(a_cmp_updates, state_q == ST_CMP, last_cmd_q[LANE_R] == cmd[LANE_R], "right command not stored")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Bezier throttle curve mapper testbench
// Streams left/right sample pairs into the mapper under several curve settings,
// predicts the command bytes each pair should send and checks every byte taken
// from the output stream in order, with random gaps and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import btcm_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE       = 48;    // accept-to-compare latency plus slack
	localparam int QUIET_LIMIT  = 4000;  // cycles with no request moved at all
	localparam int LONG_HOLD    = 400;   // output stall that backs up the input
	localparam int SHOWN_FAULTS = 10;

	// Register indexes the mapper does not implement
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] right;
		logic [SAMPLE_BITS-1:0] left;
	} sample_pair_t;

	typedef struct packed {
		logic [BYTE_W-1:0] serial_byte;
		logic              is_right;
		logic              last;
	} cmd_byte_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;    // left_sample, right_sample
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [BYTE_W-1:0]     m_tdata;           // serial_byte
	logic [0:0]            m_tuser;           // is_right
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	bezier_throttle_curve_mapper_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Pending sample pairs and the command bytes they should cause
	sample_pair_t pending_pairs[$];
	cmd_byte_t    expected_bytes[$];
	sample_pair_t prev_pair = '0;

	// Shadow of the curve registers and of the remembered commands
	logic [POWER_W-1:0] curve_lo   = MIN_POWER_RST;
	logic [POWER_W-1:0] curve_hi   = MAX_POWER_RST;
	logic [BYTE_W-1:0]  sent_left  = '0;
	logic [BYTE_W-1:0]  sent_right = '0;

	bit gaps_on     = 1'b1;
	int stall_token = 0;
	int stall_seen  = 0;
	int hold_left   = 0;
	int send_gap    = 0;
	int recv_gap    = 0;

	int fail_count   = 0;
	int pairs_taken  = 0;
	int bytes_taken  = 0;
	int reg_writes   = 0;
	int curve_sets   = 1;
	int quiet_cycles = 0;

	cmd_byte_t got_byte;
	cmd_byte_t want_byte;

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Floored cubic Bezier with control values lo, hi, lo, hi at t = idx/255
	function automatic logic [BYTE_W-1:0] bezier_cmd(input logic [IDX_W-1:0] idx);
		longint unsigned a, b, lo, hi, num;
		a   = idx;
		b   = 255 - a;
		lo  = curve_lo;
		hi  = curve_hi;
		num = lo * b * b * b + 3 * hi * a * b * b + 3 * lo * a * a * b + hi * a * a * a;
		return BYTE_W'(num / (255 * 255 * 255));
	endfunction

	// Work out the bytes one accepted pair sends and update the remembered commands
	task automatic predict_bytes(input sample_pair_t p);
		logic [BYTE_W-1:0] cmd_l, cmd_r;
		cmd_byte_t b;
		cmd_l = bezier_cmd(p.left[SAMPLE_BITS-1 -: IDX_W]);
		cmd_r = bezier_cmd(p.right[SAMPLE_BITS-1 -: IDX_W]);
		if (cmd_l != sent_left) begin
			b.serial_byte = cmd_l;
			b.is_right    = 1'b0;
			b.last        = (cmd_r == sent_right);
			expected_bytes.push_back(b);
			sent_left = cmd_l;
		end
		if (cmd_r != sent_right) begin
			b.serial_byte = cmd_r + RIGHT_OFFSET;
			b.is_right    = 1'b1;
			b.last        = 1'b1;
			expected_bytes.push_back(b);
			sent_right = cmd_r;
		end
	endtask

	function automatic void note_fault(input string msg);
		fail_count++;
		if (fail_count <= SHOWN_FAULTS)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	// Feed sample pairs from the pending queue, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_pairs.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= S_DATA_W'(pending_pairs.pop_front());
				if (gaps_on && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 4);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Accept bytes, with random stalls and one long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			recv_gap  <= 0;
		end else if (stall_seen != stall_token) begin
			stall_seen <= stall_token;
			hold_left  <= LONG_HOLD;
			m_tready   <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (gaps_on && $urandom_range(0, 5) == 0)
				recv_gap <= $urandom_range(1, 4);
		end
	end

	// Track register writes, predict on each input request, check each output request
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				if (cfg_index == REG_MIN_POWER)
					curve_lo = cfg_data[POWER_W-1:0];
				else if (cfg_index == REG_MAX_POWER)
					curve_hi = cfg_data[POWER_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				bytes_taken++;
				got_byte.serial_byte = m_tdata;
				got_byte.is_right    = m_tuser[0];
				got_byte.last        = m_tlast;
				if (expected_bytes.size() == 0) begin
					note_fault($sformatf("unexpected byte %0d is_right %0d last %0d",
						got_byte.serial_byte, got_byte.is_right, got_byte.last));
				end else begin
					want_byte = expected_bytes.pop_front();
					if (got_byte.serial_byte !== want_byte.serial_byte ||
					    got_byte.is_right !== want_byte.is_right ||
					    got_byte.last !== want_byte.last)
						note_fault($sformatf(
							"byte mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							want_byte.serial_byte, want_byte.is_right, want_byte.last,
							got_byte.serial_byte, got_byte.is_right, got_byte.last));
				end
			end
			if (s_tvalid && s_tready) begin
				pairs_taken++;
				predict_bytes(sample_pair_t'(s_tdata[2*SAMPLE_BITS-1:0]));
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	task automatic queue_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
		sample_pair_t p;
		p.left  = l;
		p.right = r;
		pending_pairs.push_back(p);
		prev_pair = p;
	endtask

	// Mostly fresh pairs, plus repeats, one-sided changes, rails and same-index jitter
	task automatic queue_random(input int count);
		sample_pair_t p;
		for (int n = 0; n < count; n++) begin
			p = prev_pair;
			case ($urandom_range(0, 9))
				5: ;
				6: p.left  = SAMPLE_BITS'($urandom);
				7: p.right = SAMPLE_BITS'($urandom);
				8: begin
					p.left  = $urandom_range(0, 1) ? '1 : '0;
					p.right = $urandom_range(0, 1) ? '1 : '0;
				end
				9: begin
					p.left[1:0]  = 2'($urandom);
					p.right[1:0] = 2'($urandom);
				end
				default: begin
					p.left  = SAMPLE_BITS'($urandom);
					p.right = SAMPLE_BITS'($urandom);
				end
			endcase
			queue_pair(p.left, p.right);
		end
	endtask

	// Wait until every pair is in and every byte is out, then let the pipeline settle
	task automatic drain();
		while (pending_pairs.size() != 0 || s_tvalid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Offer one write, drop the request after it is taken and leave the port idle before returning
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_curve(input logic [POWER_W-1:0] lo, input logic [POWER_W-1:0] hi);
		drain();
		write_reg(REG_MIN_POWER, lo);
		write_reg(REG_MAX_POWER, hi);
		curve_sets++;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed pairs under the reset curve: rails, no change, one side only,
		// low sample bits that leave the index alone
		queue_pair(10'd0, 10'd0);
		queue_pair(10'd0, 10'd0);
		queue_pair(10'd1023, 10'd1023);
		queue_pair(10'd1023, 10'd0);
		queue_pair(10'd3, 10'd0);
		queue_pair(10'd1020, 10'd3);
		queue_pair(10'd1023, 10'd1023);
		queue_pair(10'h2AA, 10'h155);
		queue_pair(10'h155, 10'h2AA);
		queue_pair(10'h155, 10'h2A9);
		queue_pair(10'd512, 10'd512);
		queue_pair(10'd511, 10'd513);
		queue_pair(10'd4, 10'd1019);
		queue_pair(10'd2, 10'd1019);

		// Low/high rails, with a long output hold while pairs keep coming
		set_curve(7'd0, 7'd127);
		queue_pair(10'd0, 10'd1023);
		queue_pair(10'd1023, 10'd0);
		queue_random(130);
		stall_token++;

		set_curve(7'd127, 7'd0);
		queue_random(120);

		// Flat curve at zero; writes to unused indexes must change nothing
		set_curve(7'd0, 7'd0);
		write_reg(REG_SPARE_A, 7'd127);
		write_reg(REG_SPARE_B, 7'd85);
		queue_random(60);

		set_curve(7'd127, 7'd127);
		write_reg(REG_SPARE_A, 7'd0);
		queue_random(120);

		set_curve(POWER_W'($urandom), POWER_W'($urandom));
		queue_random(120);

		set_curve(POWER_W'($urandom), POWER_W'($urandom));
		queue_random(120);

		// Back to the reset curve, with no gaps on either side
		set_curve(MIN_POWER_RST, MAX_POWER_RST);
		gaps_on = 1'b0;
		queue_random(150);

		drain();
		$display("covered %0d sample pairs and %0d command bytes", pairs_taken, bytes_taken);
		$display("over %0d curve settings with %0d register writes", curve_sets, reg_writes);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d faults found", fail_count);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: bezier_throttle_curve_mapper_unit.f
+incdir+src
src/btcm_pkg.sv
src/bezier_throttle_curve_mapper_unit.sv
tb/testbench.sv
